// ===== hw/rtl/ralc_pkg.sv =====
// shared types, constants and helpers for the random access load controller
// no dependencies; imported by every ralc module and the top level
package ralc_pkg;

	// restoring divider geometry: one quotient bit per stage
	localparam int unsigned DIV_N_W = 64;
	localparam int unsigned DIV_D_W = 34;
	localparam int unsigned DIV_LAT = DIV_N_W;

	// front to back queue
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW = $clog2(Q_DEPTH);

	// fixed controller constants
	localparam int unsigned AGG_FLOOR = 1;
	localparam logic [32:0] AGG_FLOOR_Q = 33'(64'(AGG_FLOOR) << 16);
	localparam logic [16:0] WIN_GAIN = 17'd32768;
	localparam logic [16:0] WIN_STEP = 17'd16;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [63:0] ELIG_NUM = 64'd1 << 33;
	localparam logic [63:0] WIN_NUM = 64'd1 << 34;

	typedef enum logic [2:0] {
		REG_TARGET_LOAD,
		REG_DEAD_BAND,
		REG_MIN_PROB,
		REG_MAX_PROB,
		REG_MIN_WIN,
		REG_MAX_WIN,
		REG_PROB_GAIN,
		REG_MAX_PROB_CHG
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] target_load;
		logic [23:0] dead_band;
		logic [16:0] min_probability;
		logic [16:0] max_probability;
		logic [15:0] min_window;
		logic [15:0] max_window;
		logic [16:0] probability_gain;
		logic [16:0] max_probability_change;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		target_load: 24'd65536,
		dead_band: 24'd6554,
		min_probability: 17'd655,
		max_probability: 17'd65536,
		min_window: 16'd1,
		max_window: 16'd1024,
		probability_gain: 17'd32768,
		max_probability_change: 17'd6554
	};

	// classified input word as it waits in the queue
	typedef struct packed {
		logic        present;
		logic        small_users;
		logic [23:0] users;
		logic [15:0] slots;
		logic [16:0] cur_p;
		logic [15:0] cur_w;
	} item_t;

	function automatic logic [16:0] clamp_p(input logic [63:0] v, input logic [16:0] lo,
			input logic [16:0] hi);
		logic [63:0] r;
		r = (v > 64'(hi)) ? 64'(hi) : v;
		if (r < 64'(lo)) r = 64'(lo);
		return r[16:0];
	endfunction

	function automatic logic [15:0] clamp_w(input logic [63:0] v, input logic [15:0] lo,
			input logic [15:0] hi);
		logic [63:0] r;
		r = (v > 64'(hi)) ? 64'(hi) : v;
		if (r < 64'(lo)) r = 64'(lo);
		return r[15:0];
	endfunction

	// max(1, w) + 1
	function automatic logic [16:0] win_div(input logic [15:0] w);
		return (w == '0) ? 17'd2 : ({1'b0, w} + 17'd1);
	endfunction

	function automatic logic [32:0] floor_agg(input logic [63:0] q);
		return (q > 64'(AGG_FLOOR_Q)) ? q[32:0] : AGG_FLOOR_Q;
	endfunction

endpackage

// ===== hw/rtl/random_access_load_controller.sv =====
// top level of the random access load controller: config registers, front, queue, back
// depends on ralc_pkg, ralc_front, ralc_queue, ralc_back (and ralc_div below it)
//
//  channel | signals                                   | direction | accepted when
//  --------+-------------------------------------------+-----------+--------------------
//  input   | in_valid, in_stall, plan_present ... window | in       | in_valid & !in_stall
//  output  | out_valid, out_stall, next_probability/win | out       | out_valid & !out_stall
//  config  | wr_en, wr_index, wr_data                  | in        | wr_en
//
// one word per cycle while the result is not stalled; each word runs through three chained
// 64-stage divider pipelines (aggressiveness, load and ratio, window) plus seven register stages.
// reset clears the config registers to their defaults and empties queue and pipeline.
// a stalled result holds the whole back end; the four-word queue keeps taking input
// until it fills, then in_stall rises.
module random_access_load_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [23:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        plan_present,
	input  logic [23:0] ready_users,
	input  logic [15:0] access_slots,
	input  logic [16:0] current_probability,
	input  logic [15:0] current_window,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] next_probability,
	output logic [15:0] next_window
);
	import ralc_pkg::*;

	cfg_t  cfg_q;
	logic  q_full, push, pop, head_valid;
	item_t push_item, head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TARGET_LOAD:  cfg_q.target_load <= wr_data;
				REG_DEAD_BAND:    cfg_q.dead_band <= wr_data;
				REG_MIN_PROB:     cfg_q.min_probability <= wr_data[16:0];
				REG_MAX_PROB:     cfg_q.max_probability <= wr_data[16:0];
				REG_MIN_WIN:      cfg_q.min_window <= wr_data[15:0];
				REG_MAX_WIN:      cfg_q.max_window <= wr_data[15:0];
				REG_PROB_GAIN:    cfg_q.probability_gain <= wr_data[16:0];
				REG_MAX_PROB_CHG: cfg_q.max_probability_change <= wr_data[16:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	ralc_front u_front (
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.plan_present       (plan_present),
		.ready_users        (ready_users),
		.access_slots       (access_slots),
		.current_probability(current_probability),
		.current_window     (current_window),
		.q_full             (q_full),
		.push               (push),
		.push_item          (push_item)
	);

	ralc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	ralc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.head_valid      (head_valid),
		.head_item       (head_item),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.next_probability(next_probability),
		.next_window     (next_window)
	);

endmodule

// ===== hw/rtl/ralc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, advances on en
// depends on ralc_pkg for its widths and latency
module ralc_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ralc_pkg::DIV_N_W-1:0] dividend,
	input  logic [ralc_pkg::DIV_D_W-1:0] divisor,
	output logic [ralc_pkg::DIV_N_W-1:0] quotient
);
	import ralc_pkg::*;

	logic [DIV_D_W-1:0] rem_q [DIV_LAT];
	logic [DIV_D_W-1:0] den_q [DIV_LAT];
	logic [DIV_N_W-1:0] nq_q [DIV_LAT];

	for (genvar i = 0; i < DIV_LAT; i++) begin : g_stage
		logic [DIV_D_W-1:0] rem_in;
		logic [DIV_D_W-1:0] den_in;
		logic [DIV_N_W-1:0] nq_in;
		logic [DIV_D_W:0]   trial;
		logic               take;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign den_in = divisor;
			assign nq_in  = dividend;
		end else begin : g_next
			assign rem_in = rem_q[i-1];
			assign den_in = den_q[i-1];
			assign nq_in  = nq_q[i-1];
		end

		// dividend bits leave at the top, quotient bits enter at the bottom
		assign trial = {rem_in, nq_in[DIV_N_W-1]};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= take ? DIV_D_W'(trial - {1'b0, den_in}) : trial[DIV_D_W-1:0];
				den_q[i] <= den_in;
				nq_q[i]  <= {nq_in[DIV_N_W-2:0], take};
			end
		end
	end

	assign quotient = nq_q[DIV_LAT-1];

endmodule

// ===== hw/rtl/ralc_front.sv =====
// front end: takes input words, classifies them and pushes them to the queue
// depends on ralc_pkg (item_t, AGG_FLOOR)
module ralc_front (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  plan_present,
	input  logic [23:0]           ready_users,
	input  logic [15:0]           access_slots,
	input  logic [16:0]           current_probability,
	input  logic [15:0]           current_window,
	input  logic                  q_full,
	output logic                  push,
	output ralc_pkg::item_t       push_item
);
	import ralc_pkg::*;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_item.present     = plan_present;
		// too few users to reach the floor: aggressiveness goes to its maximum
		push_item.small_users = {ready_users, 8'b0} <= 32'(AGG_FLOOR);
		push_item.users       = ready_users;
		push_item.slots       = (access_slots == '0) ? 16'd1 : access_slots;
		push_item.cur_p       = current_probability;
		push_item.cur_w       = current_window;
	end

endmodule

// ===== hw/rtl/ralc_queue.sv =====
// short fifo between front and back end
// depends on ralc_pkg (item_t, Q_DEPTH)
module ralc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ralc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ralc_pkg::item_t head_item
);
	import ralc_pkg::*;

	item_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	assign full       = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("queue count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> cnt_q != '0)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) push && !pop |=> cnt_q != '0)
		else $error("queue lost a word");

endmodule

// ===== hw/rtl/ralc_back.sv =====
// back end: load prediction, command and smoothing pipeline with three divider layers
// depends on ralc_pkg and ralc_div
module ralc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ralc_pkg::cfg_t  cfg,
	input  logic            head_valid,
	input  ralc_pkg::item_t head_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [16:0]     next_probability,
	output logic [15:0]     next_window
);
	import ralc_pkg::*;

	localparam int unsigned L1_N = 6;
	localparam int unsigned L1_CUR = 0;
	localparam int unsigned L1_MINAGG = 1;
	localparam int unsigned L1_MAXAGG = 2;
	localparam int unsigned L1_ELO = 3;
	localparam int unsigned L1_EHI = 4;
	localparam int unsigned L1_A = 5;
	localparam int unsigned L2_N = 2;
	localparam int unsigned L2_LOAD = 0;
	localparam int unsigned L2_RATIO = 1;

	typedef struct packed {
		logic        present;
		logic        small_users;
		logic [23:0] users;
		logic [15:0] slots;
		logic [16:0] cur_p;
		logic [15:0] cur_w;
		logic [15:0] wmin;
	} l1_side_t;

	typedef struct packed {
		logic        present;
		logic [16:0] cur_p;
		logic [15:0] cur_w;
		logic [15:0] wmin;
		logic [33:0] pmin;
		logic [32:0] elo;
		logic [32:0] ehi;
	} l2_side_t;

	typedef struct packed {
		logic        present;
		logic [16:0] cur_p;
		logic [15:0] cur_w;
		logic [15:0] wmin;
		logic [33:0] pmin;
		logic        out_band;
	} l3_side_t;

	logic en;

	// whole pipeline moves together unless the output word is held
	assign en  = !(out_valid && out_stall);
	assign pop = en && head_valid;

	// stage 1: clamps, operands for the first divider layer
	logic               v_s1;
	l1_side_t           side_s1;
	logic [DIV_N_W-1:0] n_s1 [L1_N];
	logic [DIV_D_W-1:0] d_s1 [L1_N];
	logic [DIV_N_W-1:0] q_l1 [L1_N];
	logic [15:0]        wmin_c, wmax_c;
	logic [39:0]        tgt_slots_c;

	always_comb begin
		wmin_c      = clamp_w(64'(cfg.min_window), cfg.min_window, cfg.max_window);
		wmax_c      = clamp_w(64'(cfg.max_window), cfg.min_window, cfg.max_window);
		tgt_slots_c = 40'(cfg.target_load) * 40'(head_item.slots);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.present     <= head_item.present;
			side_s1.small_users <= head_item.small_users;
			side_s1.users       <= head_item.users;
			side_s1.slots       <= head_item.slots;
			side_s1.cur_p       <= head_item.cur_p;
			side_s1.cur_w       <= head_item.cur_w;
			side_s1.wmin        <= wmin_c;
			n_s1[L1_CUR]    <= 64'({clamp_p(64'(head_item.cur_p), cfg.min_probability,
				cfg.max_probability), 17'b0});
			d_s1[L1_CUR]    <= 34'(win_div(head_item.cur_w));
			n_s1[L1_MINAGG] <= 64'({clamp_p(64'(cfg.min_probability), cfg.min_probability,
				cfg.max_probability), 17'b0});
			d_s1[L1_MINAGG] <= 34'(win_div(cfg.max_window));
			n_s1[L1_MAXAGG] <= 64'({clamp_p(64'(cfg.max_probability), cfg.min_probability,
				cfg.max_probability), 17'b0});
			d_s1[L1_MAXAGG] <= 34'(win_div(cfg.min_window));
			n_s1[L1_ELO]    <= ELIG_NUM;
			d_s1[L1_ELO]    <= 34'(win_div(wmax_c));
			n_s1[L1_EHI]    <= ELIG_NUM;
			d_s1[L1_EHI]    <= 34'(win_div(wmin_c));
			n_s1[L1_A]      <= {tgt_slots_c, 24'b0};
			d_s1[L1_A]      <= head_item.small_users ? 34'd1 : 34'(head_item.users);
		end
	end

	for (genvar k = 0; k < L1_N; k++) begin : g_l1
		ralc_div u_div (
			.clk     (clk),
			.en      (en),
			.dividend(n_s1[k]),
			.divisor (d_s1[k]),
			.quotient(q_l1[k])
		);
	end

	logic [DIV_LAT-1:0] l1_v;
	l1_side_t           l1_side [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) l1_v <= '0;
		else if (en) l1_v <= {l1_v[DIV_LAT-2:0], v_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l1_side[0] <= side_s1;
			for (int i = 1; i < DIV_LAT; i++) l1_side[i] <= l1_side[i-1];
		end
	end

	// stage 2: floors and the clamped aggressiveness target
	logic        v_s2;
	l1_side_t    side_s2;
	logic [32:0] agg_s2, a_s2, minagg_s2, maxagg_s2, elo_s2, ehi_s2;
	logic [32:0] minagg_c, maxagg_c;
	logic [63:0] a_c;

	always_comb begin
		minagg_c = floor_agg(q_l1[L1_MINAGG]);
		maxagg_c = floor_agg(q_l1[L1_MAXAGG]);
		if (l1_side[DIV_LAT-1].small_users) a_c = 64'(maxagg_c);
		else if (q_l1[L1_A] > 64'(maxagg_c)) a_c = 64'(maxagg_c);
		else a_c = q_l1[L1_A];
		if (a_c < 64'(minagg_c)) a_c = 64'(minagg_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= l1_v[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2   <= l1_side[DIV_LAT-1];
			agg_s2    <= floor_agg(q_l1[L1_CUR]);
			a_s2      <= a_c[32:0];
			minagg_s2 <= minagg_c;
			maxagg_s2 <= maxagg_c;
			elo_s2    <= q_l1[L1_ELO][32:0];
			ehi_s2    <= q_l1[L1_EHI][32:0];
		end
	end

	// stage 3: products for the load and for the probability at the smallest window
	logic               v_s3;
	l2_side_t           side_s3;
	logic [DIV_N_W-1:0] n_s3 [L2_N];
	logic [DIV_D_W-1:0] d_s3 [L2_N];
	logic [DIV_N_W-1:0] q_l2 [L2_N];
	logic [56:0]        load_prod_c;
	logic [50:0]        pmin_c;

	always_comb begin
		load_prod_c = 57'(side_s2.users) * 57'(agg_s2);
		pmin_c      = 51'(a_s2) * 51'(win_div(side_s2.wmin)) + 51'(ONE_Q16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.present <= side_s2.present;
			side_s3.cur_p   <= side_s2.cur_p;
			side_s3.cur_w   <= side_s2.cur_w;
			side_s3.wmin    <= side_s2.wmin;
			side_s3.pmin    <= pmin_c[50:17];
			side_s3.elo     <= elo_s2;
			side_s3.ehi     <= ehi_s2;
			n_s3[L2_LOAD]   <= 64'(load_prod_c);
			d_s3[L2_LOAD]   <= 34'(side_s2.slots);
			n_s3[L2_RATIO]  <= 64'({a_s2, 16'b0});
			d_s3[L2_RATIO]  <= (cfg.min_probability == '0) ? 34'd1 : 34'(cfg.min_probability);
		end
	end

	for (genvar k = 0; k < L2_N; k++) begin : g_l2
		ralc_div u_div (
			.clk     (clk),
			.en      (en),
			.dividend(n_s3[k]),
			.divisor (d_s3[k]),
			.quotient(q_l2[k])
		);
	end

	logic [DIV_LAT-1:0] l2_v;
	l2_side_t           l2_side [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) l2_v <= '0;
		else if (en) l2_v <= {l2_v[DIV_LAT-2:0], v_s3};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l2_side[0] <= side_s3;
			for (int i = 1; i < DIV_LAT; i++) l2_side[i] <= l2_side[i-1];
		end
	end

	// stage 4: band check and eligibility for the window divide
	logic        v_s4;
	l3_side_t    side_s4;
	logic [32:0] d_s4;
	logic [39:0] load_c;
	logic [23:0] low_c;
	logic [24:0] high_c;
	logic [63:0] ratio_c, dmin_c;
	logic [32:0] d_c;
	l2_side_t    l2o;

	always_comb begin
		l2o     = l2_side[DIV_LAT-1];
		load_c  = q_l2[L2_LOAD][63:24];
		low_c   = (cfg.target_load > cfg.dead_band) ? (cfg.target_load - cfg.dead_band) : '0;
		high_c  = 25'(cfg.target_load) + 25'(cfg.dead_band);
		ratio_c = (cfg.min_probability != '0) ? q_l2[L2_RATIO] : 64'(l2o.ehi);
		dmin_c  = (ratio_c < 64'(l2o.ehi)) ? ratio_c : 64'(l2o.ehi);
		d_c     = (dmin_c < 64'(l2o.elo)) ? l2o.elo : dmin_c[32:0];
		if (d_c == '0) d_c = 33'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= l2_v[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4.present  <= l2o.present;
			side_s4.cur_p    <= l2o.cur_p;
			side_s4.cur_w    <= l2o.cur_w;
			side_s4.wmin     <= l2o.wmin;
			side_s4.pmin     <= l2o.pmin;
			side_s4.out_band <= (load_c < 40'(low_c)) || (load_c > 40'(high_c));
			d_s4             <= d_c;
		end
	end

	logic [DIV_N_W-1:0] q_l3;

	ralc_div u_div_win (
		.clk     (clk),
		.en      (en),
		.dividend(WIN_NUM),
		.divisor (34'(d_s4)),
		.quotient(q_l3)
	);

	logic [DIV_LAT-1:0] l3_v;
	l3_side_t           l3_side [DIV_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) l3_v <= '0;
		else if (en) l3_v <= {l3_v[DIV_LAT-2:0], v_s4};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l3_side[0] <= side_s4;
			for (int i = 1; i < DIV_LAT; i++) l3_side[i] <= l3_side[i-1];
		end
	end

	// stage 5: command selection and distance to it
	logic               v_s5, present_s5;
	logic [16:0]        cur_p_s5;
	logic [15:0]        cur_w_s5;
	logic signed [17:0] dp_s5;
	logic signed [16:0] dw_s5;
	logic [63:0]        wq_c, w_c;
	logic [16:0]        tp_c;
	logic [15:0]        tw_c;
	l3_side_t           l3o;

	always_comb begin
		l3o  = l3_side[DIV_LAT-1];
		wq_c = (q_l3 + 64'd1) >> 1;
		w_c  = (wq_c == '0) ? '0 : (wq_c - 64'd1);
		priority if (!l3o.out_band) begin
			tp_c = l3o.cur_p;
			tw_c = l3o.cur_w;
		end else if (64'(l3o.pmin) >= 64'(cfg.min_probability)) begin
			tp_c = clamp_p(64'(l3o.pmin), cfg.min_probability, cfg.max_probability);
			tw_c = l3o.wmin;
		end else begin
			// probability pinned at its floor, window opened instead
			tp_c = cfg.min_probability;
			tw_c = clamp_w(w_c, cfg.min_window, cfg.max_window);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= l3_v[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			present_s5 <= l3o.present;
			cur_p_s5   <= l3o.cur_p;
			cur_w_s5   <= l3o.cur_w;
			dp_s5      <= $signed({1'b0, tp_c}) - $signed({1'b0, l3o.cur_p});
			dw_s5      <= $signed({1'b0, tw_c}) - $signed({1'b0, l3o.cur_w});
		end
	end

	// stage 6: gain products
	logic               v_s6, present_s6;
	logic [16:0]        cur_p_s6;
	logic [15:0]        cur_w_s6;
	logic signed [35:0] delta_p_s6;
	logic signed [34:0] delta_w_s6;
	logic [16:0]        gain_c;

	assign gain_c = (cfg.probability_gain > ONE_Q16) ? ONE_Q16 : cfg.probability_gain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			present_s6 <= present_s5;
			cur_p_s6   <= cur_p_s5;
			cur_w_s6   <= cur_w_s5;
			delta_p_s6 <= $signed({1'b0, gain_c}) * dp_s5;
			delta_w_s6 <= $signed({1'b0, WIN_GAIN}) * dw_s5;
		end
	end

	// stage 7: step limit, rounding, clamps; this is the output register
	logic               out_valid_s7, present_s7;
	logic [16:0]        np_s7;
	logic [15:0]        nw_s7;
	logic signed [36:0] lim_p_c, dl_p_c, sum_p_c, lim_w_c, dl_w_c, sum_w_c;
	logic [35:0]        rp_c, rw_c;
	logic [16:0]        np_c;
	logic [15:0]        nw_c;

	always_comb begin
		lim_p_c = $signed({4'b0, cfg.max_probability_change, 16'b0});
		dl_p_c  = $signed({{1{delta_p_s6[35]}}, delta_p_s6});
		if (dl_p_c > lim_p_c) dl_p_c = lim_p_c;
		if (dl_p_c < -lim_p_c) dl_p_c = -lim_p_c;
		sum_p_c = $signed({4'b0, cur_p_s6, 16'b0}) + dl_p_c;
		rp_c    = sum_p_c[36] ? '0 : ((sum_p_c[35:0] + 36'd32768) >> 16);
		np_c    = clamp_p(64'(rp_c), cfg.min_probability, cfg.max_probability);

		lim_w_c = $signed({4'b0, WIN_STEP, 16'b0});
		dl_w_c  = $signed({{2{delta_w_s6[34]}}, delta_w_s6});
		if (dl_w_c > lim_w_c) dl_w_c = lim_w_c;
		if (dl_w_c < -lim_w_c) dl_w_c = -lim_w_c;
		sum_w_c = $signed({5'b0, cur_w_s6, 16'b0}) + dl_w_c;
		rw_c    = sum_w_c[36] ? '0 : ((sum_w_c[35:0] + 36'd32768) >> 16);
		nw_c    = clamp_w(64'(rw_c), cfg.min_window, cfg.max_window);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_s7 <= 1'b0;
		else if (en) out_valid_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			present_s7 <= present_s6;
			np_s7      <= present_s6 ? np_c : '0;
			nw_s7      <= present_s6 ? nw_c : '0;
		end
	end

	assign out_valid        = out_valid_s7;
	assign next_probability = np_s7;
	assign next_window      = nw_s7;

	assert property (@(posedge clk) disable iff (!arst_n)
			v_s2 && minagg_s2 <= maxagg_s2 |-> a_s2 >= minagg_s2 && a_s2 <= maxagg_s2)
		else $error("aggressiveness target outside its limits");
	assert property (@(posedge clk) disable iff (!arst_n) v_s4 |-> d_s4 != '0)
		else $error("zero divisor for window");
	assert property (@(posedge clk) disable iff (!arst_n)
			out_valid_s7 && present_s7 |-> nw_s7 >= cfg.min_window)
		else $error("window below minimum");
	assert property (@(posedge clk) disable iff (!arst_n)
			out_valid_s7 && present_s7 |-> np_s7 >= cfg.min_probability)
		else $error("probability below minimum");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the random access load controller: directed and random plans checked
// against a built-in load predictor; depends on ralc_pkg and random_access_load_controller
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ralc_pkg::*;

	typedef struct {
		logic [16:0] prob;
		logic [15:0] win;
	} command_t;

	typedef struct {
		logic        present;
		logic [23:0] users;
		logic [15:0] slots;
		logic [16:0] cur_p;
		logic [15:0] cur_w;
	} plan_t;

	// load predictor with its own copy of the registers
	class load_scoreboard;
		longint unsigned tgt_load, band, p_lo, p_hi, w_lo, w_hi, p_gain, p_step;
		command_t pending[$];
		int errors;
		int checked;

		function void set_defaults();
			tgt_load = 65536; band = 6554; p_lo = 655; p_hi = 65536;
			w_lo = 1; w_hi = 1024; p_gain = 32768; p_step = 6554;
		endfunction

		function void write_reg(reg_idx_t idx, logic [23:0] d);
			case (idx)
				REG_TARGET_LOAD: tgt_load = d;
				REG_DEAD_BAND: band = d;
				REG_MIN_PROB: p_lo = d[16:0];
				REG_MAX_PROB: p_hi = d[16:0];
				REG_MIN_WIN: w_lo = d[15:0];
				REG_MAX_WIN: w_hi = d[15:0];
				REG_PROB_GAIN: p_gain = d[16:0];
				REG_MAX_PROB_CHG: p_step = d[16:0];
				default: ;
			endcase
		endfunction

		function longint unsigned limit_p(longint unsigned v);
			if (v > p_hi) v = p_hi;
			if (v < p_lo) v = p_lo;
			return v;
		endfunction

		function longint unsigned limit_w(longint unsigned v);
			if (v > w_hi) v = w_hi;
			if (v < w_lo) v = w_lo;
			return v;
		endfunction

		function longint unsigned eligibility(longint unsigned w);
			if (w < 1) w = 1;
			return (64'd1 << 33) / (w + 1);
		endfunction

		function longint unsigned aggressiveness(longint unsigned p, longint unsigned w);
			longint unsigned e;
			if (w < 1) w = 1;
			e = (limit_p(p) << 17) / (w + 1);
			return (e > 65536) ? e : 65536;
		endfunction

		function longint unsigned approach(longint unsigned c, longint unsigned t,
				longint unsigned g, longint unsigned s);
			longint d, lim, sum;
			if (g > 65536) g = 65536;
			d = longint'(g) * (longint'(t) - longint'(c));
			lim = longint'(s * 65536);
			if (d > lim) d = lim;
			if (d < -lim) d = -lim;
			sum = longint'(c * 65536) + d;
			if (sum < 0) return 0;
			return (longint'(sum) + 32768) >> 16;
		endfunction

		function void note_plan(plan_t x);
			longint unsigned u, sl, ld, lo, hi, tp, tw, a, mn, mx, wmin, wmax, pm;
			longint unsigned ratio, elo, ehi, d, w;
			command_t c;
			if (!x.present) begin
				c.prob = '0; c.win = '0;
				pending.push_back(c);
				return;
			end
			u = x.users;
			sl = (x.slots == 0) ? 1 : x.slots;
			ld = (u * aggressiveness(x.cur_p, x.cur_w) / sl) >> 24;
			lo = (tgt_load > band) ? tgt_load - band : 0;
			hi = tgt_load + band;
			tp = x.cur_p;
			tw = x.cur_w;
			if (ld < lo || ld > hi) begin
				mn = aggressiveness(p_lo, w_hi);
				mx = aggressiveness(p_hi, w_lo);
				if (u == 0 || u * 256 <= 1) a = mx;
				else begin
					a = ((tgt_load * sl) << 24) / u;
					if (a > mx) a = mx;
				end
				if (a < mn) a = mn;
				wmin = limit_w(w_lo);
				wmax = limit_w(w_hi);
				pm = (a * (((wmin < 1) ? 1 : wmin) + 1) + 65536) >> 17;
				if (pm >= p_lo) begin
					tp = limit_p(pm);
					tw = wmin;
				end else begin
					elo = eligibility(wmax);
					ehi = eligibility(wmin);
					ratio = (p_lo != 0) ? (a << 16) / p_lo : ehi;
					d = (ratio < ehi) ? ratio : ehi;
					if (d < elo) d = elo;
					if (d < 1) d = 1;
					w = ((64'd1 << 34) / d + 1) / 2;
					w = (w > 0) ? w - 1 : 0;
					tp = p_lo;
					tw = limit_w(w);
				end
			end
			c.prob = 17'(limit_p(approach(x.cur_p, tp, p_gain, p_step)));
			c.win = 16'(limit_w(approach(x.cur_w, tw, 32768, 16)));
			pending.push_back(c);
		endfunction

		function void check_command(logic [16:0] p, logic [15:0] w);
			command_t c;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word p=%0d w=%0d", $time, p, w);
				errors++;
				return;
			end
			c = pending.pop_front();
			if (p !== c.prob) begin
				$display("%0t: next_probability expected %0d actual %0d", $time, c.prob, p);
				errors++;
			end
			if (w !== c.win) begin
				$display("%0t: next_window expected %0d actual %0d", $time, c.win, w);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [2:0] wr_index = '0;
	logic [23:0] wr_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic plan_present = 0;
	logic [23:0] ready_users = '0;
	logic [15:0] access_slots = '0;
	logic [16:0] current_probability = '0;
	logic [15:0] current_window = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [16:0] next_probability;
	logic [15:0] next_window;

	random_access_load_controller u_dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	load_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_off = 0;
	longint unsigned cycles = 0;
	int directed_n = 0;
	int random_n = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver side: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_command(next_probability, next_window);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_plan(plan_t x);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		plan_present <= x.present;
		ready_users <= x.users;
		access_slots <= x.slots;
		current_probability <= x.cur_p;
		current_window <= x.cur_w;
		do @(posedge clk); while (in_stall);
		sb.note_plan(x);
	endtask

	task automatic go_idle();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] d);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		wr_en <= 0;
		sb.write_reg(idx, d);
		@(posedge clk);
	endtask

	function automatic plan_t random_plan();
		plan_t x;
		int k;
		x.present = ($urandom_range(9) != 0);
		k = $urandom_range(3);
		x.users = (k == 0) ? 24'($urandom) : (k == 1) ? 24'($urandom_range(4095))
			: (k == 2) ? 24'($urandom_range(1)) : 24'($urandom_range(65535));
		x.slots = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(64));
		x.cur_p = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
		x.cur_w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1100));
		return x;
	endfunction

	task automatic random_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) begin
			send_plan(random_plan());
			random_n++;
		end
		send_idle_pct = 0;
	endtask

	task automatic random_config();
		write_reg(REG_TARGET_LOAD, ($urandom_range(1)) ? 24'($urandom_range(200000))
			: 24'($urandom));
		write_reg(REG_DEAD_BAND, 24'($urandom_range(20000)));
		write_reg(REG_MIN_PROB, 24'($urandom_range(4000)));
		write_reg(REG_MAX_PROB, 24'($urandom_range(30000, 65536)));
		write_reg(REG_MIN_WIN, 24'($urandom_range(1, 8)));
		write_reg(REG_MAX_WIN, 24'($urandom_range(16, 65535)));
		write_reg(REG_PROB_GAIN, 24'($urandom_range(131071)));
		write_reg(REG_MAX_PROB_CHG, 24'($urandom_range(131071)));
	endtask

	initial begin
		plan_t x;
		sb.set_defaults();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, absent plan, zero slots, zero window
		x = '{1'b0, 24'hFFFFFF, 16'hFFFF, 17'h1FFFF, 16'hFFFF}; send_plan(x);
		x = '{1'b1, 24'd0, 16'd0, 17'd0, 16'd0}; send_plan(x);
		x = '{1'b1, 24'hFFFFFF, 16'd0, 17'h1FFFF, 16'd0}; send_plan(x);
		x = '{1'b1, 24'hFFFFFF, 16'hFFFF, 17'd65536, 16'hFFFF}; send_plan(x);
		x = '{1'b1, 24'd1, 16'd1, 17'd65536, 16'd1}; send_plan(x);
		x = '{1'b1, 24'd256, 16'd1, 17'd32768, 16'd1}; send_plan(x);
		x = '{1'b1, 24'd25600, 16'd1, 17'd65536, 16'd1}; send_plan(x);
		x = '{1'b1, 24'd100000, 16'd2, 17'd655, 16'd1024}; send_plan(x);
		x = '{1'b1, 24'd512, 16'd1, 17'd65536, 16'd1}; send_plan(x);
		directed_n = 9;
		go_idle();

		// minimum probability of zero and inverted limits
		write_reg(REG_MIN_PROB, 24'd0);
		write_reg(REG_MIN_WIN, 24'd0);
		write_reg(REG_PROB_GAIN, 24'h01FFFF);
		x = '{1'b1, 24'hFFFFFF, 16'd1, 17'd65536, 16'd0}; send_plan(x);
		go_idle();
		write_reg(REG_MIN_PROB, 24'h01FFFF);
		write_reg(REG_MAX_PROB, 24'd0);
		write_reg(REG_MIN_WIN, 24'hFFFF);
		write_reg(REG_MAX_WIN, 24'd1);
		write_reg(REG_TARGET_LOAD, 24'hFFFFFF);
		write_reg(REG_DEAD_BAND, 24'hFFFFFF);
		write_reg(REG_MAX_PROB_CHG, 24'h01FFFF);
		x = '{1'b1, 24'd3000, 16'd5, 17'd1000, 16'd7}; send_plan(x);
		x = '{1'b1, 24'hFFFFFF, 16'd1, 17'h1FFFF, 16'hFFFF}; send_plan(x);
		directed_n += 3;
		go_idle();

		write_reg(REG_TARGET_LOAD, 24'd0);
		write_reg(REG_DEAD_BAND, 24'd0);
		write_reg(REG_MIN_PROB, 24'd655);
		write_reg(REG_MAX_PROB, 24'd65536);
		write_reg(REG_MIN_WIN, 24'd1);
		write_reg(REG_MAX_WIN, 24'hFFFF);
		write_reg(REG_PROB_GAIN, 24'd0);
		write_reg(REG_MAX_PROB_CHG, 24'd0);
		random_phase(150, 0, 0);
		go_idle();

		// default-like settings through the idling phases
		write_reg(REG_TARGET_LOAD, 24'd65536);
		write_reg(REG_DEAD_BAND, 24'd6554);
		write_reg(REG_MAX_WIN, 24'd1024);
		write_reg(REG_PROB_GAIN, 24'd32768);
		write_reg(REG_MAX_PROB_CHG, 24'd6554);
		random_phase(300, 0, 0);
		random_phase(150, 86, 0);
		random_phase(150, 0, 86);
		random_phase(250, 33, 33);

		// long receiver hold-off while words keep coming
		hold_off = 400;
		random_phase(60, 0, 0);
		go_idle();

		repeat (4) begin
			random_config();
			random_phase(100, 0, 0);
			random_phase(50, 86, 0);
			random_phase(50, 0, 86);
			random_phase(50, 33, 33);
			go_idle();
		end

		$display("covered %0d directed and %0d random plans, %0d commands checked",
			directed_n, random_n, sb.checked);
		$display("config sweeps included inverted limits, zero gains and full-scale fields");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
